/* hdl/lss_pkg.sv */
// lss_pkg: shared types, operation codes and defaults for the linear system solver
// used by lss_ctrl, lss_dp, lss_div and linear_system_solver; no dependencies
`timescale 1ns / 1ps

package lss_pkg;

  localparam int MAX_ORDER_DEF = 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int ORDER_W       = 3;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd4;

  // datapath operation codes
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
  localparam logic [OP_W-1:0] OP_INIT      = 4'd2;
  localparam logic [OP_W-1:0] OP_RD        = 4'd3;
  localparam logic [OP_W-1:0] OP_SRCH      = 4'd4;
  localparam logic [OP_W-1:0] OP_SWAP      = 4'd5;
  localparam logic [OP_W-1:0] OP_DIV_START = 4'd6;
  localparam logic [OP_W-1:0] OP_WR_DIV    = 4'd7;
  localparam logic [OP_W-1:0] OP_CAP_S     = 4'd8;
  localparam logic [OP_W-1:0] OP_CAP_Q     = 4'd9;
  localparam logic [OP_W-1:0] OP_MUL       = 4'd10;
  localparam logic [OP_W-1:0] OP_WR_ELIM   = 4'd11;
  localparam logic [OP_W-1:0] OP_OUT       = 4'd12;
  localparam logic [OP_W-1:0] OP_OUT_SING  = 4'd13;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            first;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic div_done;
    logic rd_zero;
  } sts_t;

endpackage

/* hdl/lss_ram.sv */
// lss_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/lss_div.sv */
// lss_div: radix-2 restoring divider, (x * 2^F) / p truncated toward zero, saturated to 32 bits
// depends on lss_pkg
`timescale 1ns / 1ps

module lss_div #(
  parameter int FRAC_BITS = lss_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [lss_pkg::DATA_W-1:0] dividend,
  input  logic signed [lss_pkg::DATA_W-1:0] divisor,
  output logic                              done,
  output logic        [lss_pkg::DATA_W-1:0] quotient
);

  localparam int DW   = lss_pkg::DATA_W + FRAC_BITS;
  localparam int CNTW = $clog2(DW + 1);
  localparam logic [DW-1:0] LIM_POS = {{(DW-32){1'b0}}, 32'h7FFF_FFFF};
  localparam logic [DW-1:0] LIM_NEG = {{(DW-32){1'b0}}, 32'h8000_0000};

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]   num_r, num_nxt;
  logic [31:0]     rem_r, rem_nxt;
  logic [31:0]     b_r, b_nxt;
  logic            neg_r, neg_nxt;
  logic [32:0]     trial;
  logic [31:0]     mag_x, mag_p;

  assign mag_x = dividend[31] ? 32'(-dividend) : dividend;
  assign mag_p = divisor[31] ? 32'(-divisor) : divisor;
  assign trial = {rem_r, num_r[DW-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    b_nxt    = b_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(DW);
      num_nxt  = {mag_x, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      b_nxt    = mag_p;
      neg_nxt  = dividend[31] ^ divisor[31];
    end else if (busy_r) begin
      if (trial >= {1'b0, b_r}) begin
        rem_nxt = 32'(trial - {1'b0, b_r});
        num_nxt = {num_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        num_nxt = {num_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    b_r   <= b_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    if (neg_r) begin
      quotient = (num_r > LIM_NEG) ? 32'h8000_0000 : 32'(LIM_NEG - LIM_NEG - num_r);
    end else begin
      quotient = (num_r > LIM_POS) ? 32'h7FFF_FFFF : num_r[31:0];
    end
  end

  assign done = done_r;

endmodule

/* hdl/lss_dp.sv */
// lss_dp: solver datapath, matrix ram, row permutation, pivot search, divider and multiply-subtract
// depends on lss_pkg, lss_ram, lss_div
`timescale 1ns / 1ps

module lss_dp #(
  parameter int MAX_ORDER = lss_pkg::MAX_ORDER_DEF,
  parameter int FRAC_BITS = lss_pkg::FRAC_BITS_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  lss_pkg::cmd_t                                          cmd,
  output lss_pkg::sts_t                                          sts,
  input  logic [$clog2(MAX_ORDER+1)-1:0]                         n,
  input  logic [$clog2(MAX_ORDER)-1:0]                           row,
  input  logic [$clog2(MAX_ORDER+1)-1:0]                         col,
  input  logic [$clog2(MAX_ORDER*(MAX_ORDER+1))-1:0]             load_addr,
  input  logic signed [lss_pkg::DATA_W-1:0]                      in_coefficient,
  output logic                                                   out_strobe,
  output logic signed [lss_pkg::DATA_W-1:0]                      out_solution_value,
  output logic                                                   out_last_of_run,
  output logic                                                   out_singular
);

  localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ORDER);

  logic [RW-1:0]        perm_r [MAX_ORDER];
  logic [32:0]          best_mag_r;
  logic signed [31:0]   best_val_r;
  logic [RW-1:0]        best_row_r;
  logic                 found_r;
  logic signed [31:0]   s_r, q_r, y_r;
  logic signed [63:0]   prod_r;
  logic                 strobe_r;
  logic signed [31:0]   value_r;
  logic                 last_r, sing_r;

  logic [AW-1:0]        addr;
  logic                 we, re;
  logic [AW-1:0]        waddr;
  logic [31:0]          wdata;
  logic signed [31:0]   rd_data;
  logic [32:0]          cand_mag;
  logic                 div_done;
  logic [31:0]          div_q;
  logic signed [63:0]   diff;
  logic [31:0]          elim_val;

  assign addr = AW'(perm_r[row]) * (AW'(n) + AW'(1)) + AW'(col);

  assign we = (cmd.op == lss_pkg::OP_LOAD) || (cmd.op == lss_pkg::OP_WR_DIV) ||
              (cmd.op == lss_pkg::OP_WR_ELIM);
  assign re = (cmd.op == lss_pkg::OP_RD);
  assign waddr = (cmd.op == lss_pkg::OP_LOAD) ? load_addr : addr;

  // floor of the scaled product, then saturating subtract
  assign diff = 64'(y_r) - (prod_r >>> FRAC_BITS);
  always_comb begin
    if (diff > 64'sh7FFF_FFFF) begin
      elim_val = 32'h7FFF_FFFF;
    end else if (diff < -64'sh8000_0000) begin
      elim_val = 32'h8000_0000;
    end else begin
      elim_val = diff[31:0];
    end
  end

  always_comb begin
    unique case (cmd.op)
      lss_pkg::OP_LOAD:   wdata = in_coefficient;
      lss_pkg::OP_WR_DIV: wdata = div_q;
      default:            wdata = elim_val;
    endcase
  end

  lss_ram #(
    .WIDTH(lss_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(addr),
    .rdata(rd_data)
  );

  lss_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.op == lss_pkg::OP_DIV_START),
    .dividend(rd_data),
    .divisor (best_val_r),
    .done    (div_done),
    .quotient(div_q)
  );

  assign cand_mag = rd_data[31] ? 33'(-$signed({rd_data[31], rd_data})) : {1'b0, rd_data};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (cmd.op == lss_pkg::OP_OUT) || (cmd.op == lss_pkg::OP_OUT_SING);
      if (cmd.op == lss_pkg::OP_SRCH) begin
        if (cmd.first) begin
          found_r <= (cand_mag != '0);
        end else if (cand_mag > best_mag_r) begin
          found_r <= 1'b1;
        end
      end
    end
    unique case (cmd.op)
      lss_pkg::OP_INIT: begin
        for (int i = 0; i < MAX_ORDER; i++) begin
          perm_r[i] <= RW'(i);
        end
      end
      lss_pkg::OP_SRCH: begin
        if (cmd.first || (cand_mag > best_mag_r)) begin
          best_mag_r <= cand_mag;
          best_val_r <= rd_data;
          best_row_r <= row;
        end
      end
      lss_pkg::OP_SWAP: begin
        perm_r[row]        <= perm_r[best_row_r];
        perm_r[best_row_r] <= perm_r[row];
      end
      lss_pkg::OP_CAP_S: s_r <= rd_data;
      lss_pkg::OP_CAP_Q: q_r <= rd_data;
      lss_pkg::OP_MUL: begin
        prod_r <= 64'(q_r) * 64'(s_r);
        y_r    <= rd_data;
      end
      lss_pkg::OP_OUT: begin
        value_r <= rd_data;
        last_r  <= cmd.last;
        sing_r  <= 1'b0;
      end
      lss_pkg::OP_OUT_SING: begin
        value_r <= '0;
        last_r  <= cmd.last;
        sing_r  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sts.found    = found_r;
  assign sts.div_done = div_done;
  assign sts.rd_zero  = (rd_data == '0);

  assign out_strobe         = strobe_r;
  assign out_solution_value = value_r;
  assign out_last_of_run    = last_r;
  assign out_singular       = sing_r;

endmodule

/* hdl/lss_ctrl.sv */
// lss_ctrl: solver sequencer, loading, pivot search, scaling, elimination and result readout
// depends on lss_pkg
`timescale 1ns / 1ps

module lss_ctrl #(
  parameter int MAX_ORDER = lss_pkg::MAX_ORDER_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  output logic                                       busy,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [lss_pkg::ORDER_W-1:0]                cfg_order,
  output lss_pkg::cmd_t                              cmd,
  input  lss_pkg::sts_t                              sts,
  output logic [$clog2(MAX_ORDER+1)-1:0]             n,
  output logic [$clog2(MAX_ORDER)-1:0]               row,
  output logic [$clog2(MAX_ORDER+1)-1:0]             col,
  output logic [$clog2(MAX_ORDER*(MAX_ORDER+1))-1:0] load_addr
);

  localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(MAX_ORDER);
  localparam int NW    = $clog2(MAX_ORDER + 1);

  localparam logic [4:0] S_LOAD    = 5'd0;
  localparam logic [4:0] S_INIT    = 5'd1;
  localparam logic [4:0] S_SR_RD   = 5'd2;
  localparam logic [4:0] S_SR_CMP  = 5'd3;
  localparam logic [4:0] S_SR_END  = 5'd4;
  localparam logic [4:0] S_DV_RD   = 5'd5;
  localparam logic [4:0] S_DV_GO   = 5'd6;
  localparam logic [4:0] S_DV_WAIT = 5'd7;
  localparam logic [4:0] S_EL_SRD  = 5'd8;
  localparam logic [4:0] S_EL_SCAP = 5'd9;
  localparam logic [4:0] S_EL_QRD  = 5'd10;
  localparam logic [4:0] S_EL_QCAP = 5'd11;
  localparam logic [4:0] S_EL_YRD  = 5'd12;
  localparam logic [4:0] S_EL_MUL  = 5'd13;
  localparam logic [4:0] S_EL_WR   = 5'd14;
  localparam logic [4:0] S_OUT_RD  = 5'd15;
  localparam logic [4:0] S_OUT     = 5'd16;
  localparam logic [4:0] S_SING    = 5'd17;

  logic [4:0]                  state_r, state_nxt;
  logic [lss_pkg::ORDER_W-1:0] order_r, order_nxt;
  logic [LW-1:0]               load_cnt_r, load_cnt_nxt;
  logic [RW-1:0]               k_r, k_nxt;
  logic [RW-1:0]               r_r, r_nxt;
  logic [NW-1:0]               c_r, c_nxt;
  logic [NW-1:0]               n_eff;
  logic [LW-1:0]               total;
  logic                        last_row, last_col, last_k, adv;

  always_comb begin
    if (order_r < 3'd2) begin
      n_eff = NW'(2);
    end else if (int'(order_r) > MAX_ORDER) begin
      n_eff = NW'(MAX_ORDER);
    end else begin
      n_eff = NW'(order_r);
    end
  end

  assign total    = LW'(n_eff) * (LW'(n_eff) + LW'(1));
  assign last_row = (r_r == RW'(n_eff - NW'(1)));
  assign last_k   = (k_r == RW'(n_eff - NW'(1)));
  assign last_col = (c_r == n_eff);

  always_comb begin
    state_nxt    = state_r;
    order_nxt    = order_r;
    load_cnt_nxt = load_cnt_r;
    k_nxt        = k_r;
    r_nxt        = r_r;
    c_nxt        = c_r;
    adv          = 1'b0;
    cmd          = '{op: lss_pkg::OP_NONE, first: 1'b0, last: 1'b0};
    row          = r_r;
    col          = c_r;
    unique case (state_r)
      S_LOAD: begin
        if (cfg_valid && cfg_ready) begin
          order_nxt    = cfg_order;
          load_cnt_nxt = '0;
        end else if (start) begin
          cmd.op = lss_pkg::OP_LOAD;
          if (load_cnt_r == total - LW'(1)) begin
            load_cnt_nxt = '0;
            state_nxt    = S_INIT;
          end else begin
            load_cnt_nxt = load_cnt_r + LW'(1);
          end
        end
      end
      S_INIT: begin
        cmd.op    = lss_pkg::OP_INIT;
        k_nxt     = '0;
        r_nxt     = '0;
        state_nxt = S_SR_RD;
      end
      S_SR_RD: begin
        cmd.op    = lss_pkg::OP_RD;
        col       = NW'(k_r);
        state_nxt = S_SR_CMP;
      end
      S_SR_CMP: begin
        cmd.op    = lss_pkg::OP_SRCH;
        cmd.first = (r_r == k_r);
        if (last_row) begin
          state_nxt = S_SR_END;
        end else begin
          r_nxt     = r_r + RW'(1);
          state_nxt = S_SR_RD;
        end
      end
      S_SR_END: begin
        if (!sts.found) begin
          r_nxt     = '0;
          state_nxt = S_SING;
        end else begin
          cmd.op    = lss_pkg::OP_SWAP;
          row       = k_r;
          c_nxt     = NW'(k_r) + NW'(1);
          state_nxt = S_DV_RD;
        end
      end
      S_DV_RD: begin
        cmd.op    = lss_pkg::OP_RD;
        row       = k_r;
        state_nxt = S_DV_GO;
      end
      S_DV_GO: begin
        cmd.op    = lss_pkg::OP_DIV_START;
        state_nxt = S_DV_WAIT;
      end
      S_DV_WAIT: begin
        if (sts.div_done) begin
          cmd.op = lss_pkg::OP_WR_DIV;
          row    = k_r;
          if (last_col) begin
            r_nxt     = '0;
            state_nxt = S_EL_SRD;
          end else begin
            c_nxt     = c_r + NW'(1);
            state_nxt = S_DV_RD;
          end
        end
      end
      S_EL_SRD: begin
        if (r_r == k_r) begin
          adv = 1'b1;
        end else begin
          cmd.op    = lss_pkg::OP_RD;
          col       = NW'(k_r);
          state_nxt = S_EL_SCAP;
        end
      end
      S_EL_SCAP: begin
        cmd.op = lss_pkg::OP_CAP_S;
        if (sts.rd_zero) begin
          adv = 1'b1;
        end else begin
          c_nxt     = NW'(k_r) + NW'(1);
          state_nxt = S_EL_QRD;
        end
      end
      S_EL_QRD: begin
        cmd.op    = lss_pkg::OP_RD;
        row       = k_r;
        state_nxt = S_EL_QCAP;
      end
      S_EL_QCAP: begin
        cmd.op    = lss_pkg::OP_CAP_Q;
        state_nxt = S_EL_YRD;
      end
      S_EL_YRD: begin
        cmd.op    = lss_pkg::OP_RD;
        state_nxt = S_EL_MUL;
      end
      S_EL_MUL: begin
        cmd.op    = lss_pkg::OP_MUL;
        state_nxt = S_EL_WR;
      end
      S_EL_WR: begin
        cmd.op = lss_pkg::OP_WR_ELIM;
        if (last_col) begin
          adv = 1'b1;
        end else begin
          c_nxt     = c_r + NW'(1);
          state_nxt = S_EL_QRD;
        end
      end
      S_OUT_RD: begin
        cmd.op    = lss_pkg::OP_RD;
        col       = n_eff;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.op   = lss_pkg::OP_OUT;
        cmd.last = last_row;
        if (last_row) begin
          state_nxt = S_LOAD;
        end else begin
          r_nxt     = r_r + RW'(1);
          state_nxt = S_OUT_RD;
        end
      end
      S_SING: begin
        cmd.op   = lss_pkg::OP_OUT_SING;
        cmd.last = last_row;
        if (last_row) begin
          state_nxt = S_LOAD;
        end else begin
          r_nxt = r_r + RW'(1);
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
    // next row of elimination, or next column, or readout
    if (adv) begin
      if (!last_row) begin
        r_nxt     = r_r + RW'(1);
        state_nxt = S_EL_SRD;
      end else if (last_k) begin
        r_nxt     = '0;
        state_nxt = S_OUT_RD;
      end else begin
        k_nxt     = k_r + RW'(1);
        r_nxt     = k_r + RW'(1);
        state_nxt = S_SR_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      order_r    <= lss_pkg::ORDER_RESET;
      load_cnt_r <= '0;
      k_r        <= '0;
      r_r        <= '0;
      c_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      order_r    <= order_nxt;
      load_cnt_r <= load_cnt_nxt;
      k_r        <= k_nxt;
      r_r        <= r_nxt;
      c_r        <= c_nxt;
    end
  end

  assign busy      = (state_r != S_LOAD);
  assign cfg_ready = (state_r == S_LOAD) && !start;
  assign n         = n_eff;
  assign load_addr = load_cnt_r[AW-1:0];

endmodule

/* hdl/linear_system_solver.sv */
// linear_system_solver: n-by-n gauss-jordan solver with partial pivoting, signed fixed point
// sequence: load of the n*(n+1) coefficients, then per column k a pivot search over rows k to n-1,
// a divide of the pivot row by the pivot and a multiply-subtract on every other row with a nonzero
// entry in column k, then readout of the results (zeros when singular); the ram and divider set the pace
// one run at a time: busy is high from the last coefficient transfer until the last result
// synchronous active-low reset clears the sequencer, load count and order (back to 4)
// depends on lss_pkg, lss_ctrl, lss_dp
`timescale 1ns / 1ps

module linear_system_solver #(
  parameter int MAX_ORDER = lss_pkg::MAX_ORDER_DEF,
  parameter int FRAC_BITS = lss_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // coefficient transfer, row-major augmented matrix
  input  logic                              start,
  output logic                              busy,
  input  logic signed [lss_pkg::DATA_W-1:0] in_coefficient,
  // order register write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lss_pkg::ORDER_W-1:0]       cfg_order,
  // results, one cycle each, no backpressure
  output logic                              out_strobe,
  output logic signed [lss_pkg::DATA_W-1:0] out_solution_value,
  output logic                              out_last_of_run,
  output logic                              out_singular
);

  localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1);

  lss_pkg::cmd_t                   cmd;
  lss_pkg::sts_t                   sts;
  logic [$clog2(MAX_ORDER+1)-1:0]  n;
  logic [$clog2(MAX_ORDER)-1:0]    row;
  logic [$clog2(MAX_ORDER+1)-1:0]  col;
  logic [$clog2(DEPTH)-1:0]        load_addr;

  // sequencer: walks load, pivot search, row scaling, elimination, readout
  lss_ctrl #(
    .MAX_ORDER(MAX_ORDER)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_order(cfg_order),
    .cmd      (cmd),
    .sts      (sts),
    .n        (n),
    .row      (row),
    .col      (col),
    .load_addr(load_addr)
  );

  // datapath: matrix ram behind a row permutation, divider, multiplier
  lss_dp #(
    .MAX_ORDER(MAX_ORDER),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .n                 (n),
    .row               (row),
    .col               (col),
    .load_addr         (load_addr),
    .in_coefficient    (in_coefficient),
    .out_strobe        (out_strobe),
    .out_solution_value(out_solution_value),
    .out_last_of_run   (out_last_of_run),
    .out_singular      (out_singular)
  );

  // only the final result may coincide with the solver going idle
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_of_run |-> busy)
    else $error("non-final result while idle");

  // a singular run reports zero values
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_singular |-> out_solution_value == '0)
    else $error("singular result with nonzero value");

  // no result right after a coefficient transfer
  a_no_result_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_strobe)
    else $error("result right after a coefficient transfer");

  // config transfers only while idle
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !busy)
    else $error("config ready while busy");

endmodule
